// ===== rtl/core/slsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsc_pkg: shared types and constants
// Request and result layouts and the character codes used by the line parser
// of the serial line display capture block.
// ----------------------------------------------------------------------------
package slsc_pkg;

	localparam logic [7:0] CHAR_CR = 8'd13;
	localparam logic [7:0] CHAR_LF = 8'd10;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_SCAN = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       echo_valid;
		logic [7:0] echo_byte;
		logic       scan_valid;
		logic [1:0] digit_index;
		logic [7:0] digit_char;
	} result_t;

endpackage

// ===== rtl/core/slsc_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsc_channels: handshake channels
// Request channel (byte or scan tick) and result channel, each with valid,
// ready and the payload fields.
// ----------------------------------------------------------------------------
interface slsc_item_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface slsc_result_if;
	logic       valid;
	logic       ready;
	logic       echo_valid;
	logic [7:0] echo_byte;
	logic       scan_valid;
	logic [1:0] digit_index;
	logic [7:0] digit_char;

	modport source (output valid, output echo_valid, output echo_byte,
		output scan_valid, output digit_index, output digit_char, input ready);
	modport sink (input valid, input echo_valid, input echo_byte,
		input scan_valid, input digit_index, input digit_char, output ready);
endinterface

// ===== rtl/core/serial_line_seven_segment_capture_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_seven_segment_capture_top: serial line capture for a display
// Stores the first characters of each received line in the digit buffer,
// echoes the rest, and reports one digit position per scan tick.
// ----------------------------------------------------------------------------
//  channel   direction   contents
//  item      in          op (byte or scan tick), rx_byte
//  result    out         echo_valid, echo_byte, scan_valid, digit_index,
//                        digit_char
//
// Every request gives exactly one result: it passes through the request
// register and then the result register.
// One request is taken per cycle while the result side does not stall; the
// parser state and buffer update as a request leaves the request register.
// Reset clears the parser phase, the buffer and the scan position.
// A stalled result holds the request register, which then refuses new ones.
// ----------------------------------------------------------------------------
module serial_line_seven_segment_capture_top #(
	parameter int DIGITS = 4
) (
	input logic          clk,
	input logic          arst_n,
	slsc_item_if.sink    item,
	slsc_result_if.source result
);
	import slsc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    adv;
	result_t res_d;
	result_t res_q;
	logic    out_valid_q;

	assign adv        = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.op      <= item.op;
			item_s1.rx_byte <= item.rx_byte;
		end
	end

	slsc_engine #(
		.DIGITS(DIGITS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.item  (item_s1),
		.res   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.echo_valid  = res_q.echo_valid;
	assign result.echo_byte   = res_q.echo_byte;
	assign result.scan_valid  = res_q.scan_valid;
	assign result.digit_index = res_q.digit_index;
	assign result.digit_char  = res_q.digit_char;

endmodule

// ===== rtl/core/slsc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slsc_engine: line parser, digit buffer and scan position
// Computes the result of one request and updates the parser state, the
// character buffer and the scan position when the request advances.
// ----------------------------------------------------------------------------
module slsc_engine #(
	parameter int DIGITS = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  slsc_pkg::item_t   item,
	output slsc_pkg::result_t res
);
	import slsc_pkg::*;

	localparam int PW = $clog2(DIGITS + 2);
	localparam int SW = $clog2(DIGITS);
	localparam logic [PW-1:0] PHASE_PASS = PW'(DIGITS);
	localparam logic [PW-1:0] PHASE_EOL  = PW'(DIGITS + 1);
	localparam logic [SW-1:0] LAST_POS   = SW'(DIGITS - 1);

	logic [PW-1:0] phase_q, phase_d;
	logic [SW-1:0] scan_pos_q, scan_pos_d;
	logic [7:0]    chars_q [DIGITS];
	logic          wr_en;
	logic [SW-1:0] wr_addr;
	logic          is_eol;

	assign is_eol = (item.rx_byte == CHAR_CR) || (item.rx_byte == CHAR_LF);

	always_comb begin
		phase_d    = phase_q;
		scan_pos_d = scan_pos_q;
		wr_en      = 1'b0;
		wr_addr    = '0;
		res        = '0;
		if (item.op == OP_SCAN) begin
			res.scan_valid  = 1'b1;
			res.digit_index = 2'(scan_pos_q);
			res.digit_char  = chars_q[scan_pos_q];
			scan_pos_d      = (scan_pos_q == LAST_POS) ? '0 : scan_pos_q + 1'b1;
		end else if (phase_q < PHASE_PASS) begin
			wr_en   = 1'b1;
			wr_addr = phase_q[SW-1:0];
			phase_d = phase_q + 1'b1;
		end else if (phase_q == PHASE_PASS) begin
			res.echo_valid = 1'b1;
			res.echo_byte  = item.rx_byte;
			if (is_eol) begin
				phase_d = PHASE_EOL;
			end
		end else begin
			// After the end of a line, only a non line-end byte opens a new line.
			if (is_eol) begin
				res.echo_valid = 1'b1;
				res.echo_byte  = item.rx_byte;
			end else begin
				wr_en   = 1'b1;
				wr_addr = '0;
				phase_d = PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			scan_pos_q <= '0;
			for (int i = 0; i < DIGITS; i++) begin
				chars_q[i] <= '0;
			end
		end else if (en) begin
			phase_q    <= phase_d;
			scan_pos_q <= scan_pos_d;
			if (wr_en) begin
				chars_q[wr_addr] <= item.rx_byte;
			end
		end
	end

endmodule

// ===== test/tb_serial_line_seven_segment_capture_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serial_line_seven_segment_capture_top: line capture and scan testbench
// Sends byte and scan tick requests to the display capture block. It tracks
// the line parser, the digit buffer and the scan position on its own, and
// checks every result field against the oldest outstanding request. Both
// handshake sides pause at random. One long receiver hold fills the block.
// ----------------------------------------------------------------------------
module tb_serial_line_seven_segment_capture_top;
	import slsc_pkg::*;

	localparam int DIGITS      = 4;
	localparam int PHASE_PASS  = DIGITS;
	localparam int PHASE_EOL   = DIGITS + 1;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD   = 300;

	logic clk;
	logic arst_n;

	slsc_item_if   item_ch ();
	slsc_result_if result_ch ();

	serial_line_seven_segment_capture_top #(
		.DIGITS (DIGITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Own copy of the parser phase, the digit buffer and the scan position.
	int         line_phase;
	logic [7:0] shown_chars [DIGITS];
	int         scan_pos;

	result_t display_out_q [$];
	int      mismatch_count;
	int      idle_cycles;
	int      items_sent;
	int      rx_hold_request;
	bit      tx_gaps_en;
	bit      rx_idle_en;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_line_end(logic [7:0] c);
		return c == CHAR_CR || c == CHAR_LF;
	endfunction

	function automatic result_t line_capture_step(logic op, logic [7:0] c);
		result_t r;
		r = '0;
		if (op == OP_SCAN) begin
			r.scan_valid  = 1'b1;
			r.digit_index = scan_pos[1:0];
			r.digit_char  = shown_chars[scan_pos];
			scan_pos      = (scan_pos + 1) % DIGITS;
		end else if (line_phase < PHASE_PASS) begin
			shown_chars[line_phase] = c;
			line_phase++;
		end else if (line_phase == PHASE_PASS) begin
			r.echo_valid = 1'b1;
			r.echo_byte  = c;
			if (is_line_end(c))
				line_phase = PHASE_EOL;
		end else if (is_line_end(c)) begin
			r.echo_valid = 1'b1;
			r.echo_byte  = c;
		end else begin
			// Any other byte after the line end opens a new line.
			shown_chars[0] = c;
			line_phase     = 1;
		end
		return r;
	endfunction

	function automatic logic [7:0] any_char();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return CHAR_CR;
			1: return CHAR_LF;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		c = any_char();
		while (is_line_end(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		if (!tx_gaps_en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic op, input logic [7:0] c);
		int gap;
		@(negedge clk);
		item_ch.valid   <= 1'b1;
		item_ch.op      <= op;
		item_ch.rx_byte <= c;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		display_out_q.push_back(line_capture_step(op, c));
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_item(OP_BYTE, c);
	endtask

	task automatic send_scan();
		// The byte field is ignored on a scan tick, so it carries noise.
		send_item(OP_SCAN, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_line_byte(input logic [7:0] c);
		if ($urandom_range(0, 3) == 0)
			send_scan();
		send_byte(c);
	endtask

	task automatic test_reset_scan();
		repeat (DIGITS + 1) send_scan();
	endtask

	task automatic test_line_storage();
		// Line end codes are stored like any other byte while the line opens.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		repeat (DIGITS) send_scan();
	endtask

	task automatic test_echo_and_new_line();
		send_byte(8'h41);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CHAR_LF);
		send_byte(CHAR_CR);
		send_byte(CHAR_LF);
		send_byte(8'h7A);
		send_byte(8'h80);
		repeat (2) send_scan();
	endtask

	task automatic test_random_lines(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(0, 99) < 85) begin
				repeat (DIGITS) send_line_byte(any_char());
				repeat ($urandom_range(0, 6)) send_line_byte(text_char());
				repeat ($urandom_range(1, 3))
					send_line_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
			end else begin
				repeat ($urandom_range(1, 10))
					send_item(1'($urandom_range(0, 1)), any_char());
			end
		end
	endtask

	task automatic test_backpressure();
		// The receiver holds off while requests keep coming back to back.
		tx_gaps_en      = 1'b0;
		rx_hold_request = LONG_HOLD;
		repeat (40) send_item(1'($urandom_range(0, 1)), any_char());
		tx_gaps_en = 1'b1;
	endtask

	task automatic test_no_idle();
		tx_gaps_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_lines(200);
		tx_gaps_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	// Result receiver with random holds, short ones mostly.
	initial begin
		int hold_left;
		int r;
		hold_left       = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_request > 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end else if (hold_left == 0 && rx_idle_en) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					hold_left = $urandom_range(1, 3);
				else if (r < 17)
					hold_left = $urandom_range(10, 40);
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (display_out_q.size() == 0) begin
				$error("result with no request outstanding");
				mismatch_count++;
			end else begin
				want = display_out_q.pop_front();
				check_field("echo_valid", 8'(want.echo_valid), 8'(result_ch.echo_valid));
				check_field("echo_byte", want.echo_byte, result_ch.echo_byte);
				check_field("scan_valid", 8'(want.scan_valid), 8'(result_ch.scan_valid));
				check_field("digit_index", 8'(want.digit_index),
					8'(result_ch.digit_index));
				check_field("digit_char", want.digit_char, result_ch.digit_char);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.op      = OP_BYTE;
		item_ch.rx_byte = 8'h00;
		mismatch_count  = 0;
		idle_cycles     = 0;
		items_sent      = 0;
		rx_hold_request = 0;
		tx_gaps_en      = 1'b1;
		rx_idle_en      = 1'b1;
		line_phase      = 0;
		scan_pos        = 0;
		for (int i = 0; i < DIGITS; i++)
			shown_chars[i] = 8'h00;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_scan();
		test_line_storage();
		test_echo_and_new_line();
		test_random_lines(1250);
		test_backpressure();
		test_no_idle();
		test_random_lines(250);

		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (display_out_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== serial_line_seven_segment_capture_top.f =====
rtl/core/slsc_pkg.sv
rtl/core/slsc_channels.sv
rtl/core/slsc_engine.sv
rtl/core/serial_line_seven_segment_capture_top.sv
test/tb_serial_line_seven_segment_capture_top.sv
